// ----- rtl/apm_pkg.sv -----
`default_nettype none
package apm_pkg;

  localparam int HIST_DEPTH  = 128;
  localparam int HIST_AW     = $clog2(HIST_DEPTH);
  localparam int MAX_SAMPLES = 4096;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int SAMPLE_W    = 16;
  localparam int AGE_W       = 7;
  localparam int LEVEL_W     = 16;
  localparam int SQ_W        = 31;                 // 32768^2 fits in 31 bits
  localparam int SUM_W       = 43;
  localparam int ROOT_W      = 16;
  localparam int MEAN_W      = 2 * ROOT_W;
  localparam int STEP_W      = $clog2(SUM_W);
  localparam int REM_W       = CNT_W + 1;
  localparam int SREM_W      = ROOT_W + 2;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_READ   = 1'b1;
  localparam logic KIND_LEVEL = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load_in;
    logic square;
    logic accum;
    logic div_init;
    logic div_step;
    logic sqrt_init;
    logic sqrt_step;
    logic mem_rd;
    logic emit_level;
    logic emit_read;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_read;
    logic is_end;
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

// ----- rtl/apm_ctrl.sv -----
`default_nettype none
module apm_ctrl
  import apm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ACC,
    ST_DINIT,
    ST_DIV,
    ST_SINIT,
    ST_SQRT,
    ST_EMIT,
    ST_RDOUT
  } state_t;

  state_t              state_r;
  logic [STEP_W-1:0]   step_r;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.load_in    = in_ready && in_valid;
    cmd.square     = (state_r == ST_LOAD);
    cmd.mem_rd     = (state_r == ST_LOAD) && sts.is_read;
    cmd.accum      = (state_r == ST_ACC);
    cmd.div_init   = (state_r == ST_DINIT);
    cmd.div_step   = (state_r == ST_DIV);
    cmd.sqrt_init  = (state_r == ST_SINIT);
    cmd.sqrt_step  = (state_r == ST_SQRT);
    cmd.emit_level = (state_r == ST_EMIT) && sts.out_free;
    cmd.emit_read  = (state_r == ST_RDOUT) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) state_r <= ST_LOAD;
        end
        ST_LOAD: begin
          state_r <= sts.is_read ? ST_RDOUT : ST_ACC;
        end
        ST_ACC: begin
          state_r <= sts.is_end ? ST_DINIT : ST_IDLE;
        end
        ST_DINIT: begin
          step_r  <= STEP_W'(SUM_W - 1);
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (step_r == '0) state_r <= ST_SINIT;
          else step_r <= step_r - 1'b1;
        end
        ST_SINIT: begin
          step_r  <= STEP_W'(ROOT_W - 1);
          state_r <= ST_SQRT;
        end
        ST_SQRT: begin
          if (step_r == '0) state_r <= ST_EMIT;
          else step_r <= step_r - 1'b1;
        end
        ST_EMIT: begin
          if (sts.out_free) state_r <= ST_IDLE;
        end
        ST_RDOUT: begin
          if (sts.out_free) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/apm_dpath.sv -----
`default_nettype none
module apm_dpath
  import apm_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire dp_cmd_t                    cmd,
  output dp_sts_t                         sts,
  input  wire logic                       in_cmd,
  input  wire logic signed [SAMPLE_W-1:0] in_sample,
  input  wire logic                       in_end,
  input  wire logic [AGE_W-1:0]           in_age,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_kind,
  output logic [LEVEL_W-1:0]              out_level,
  output logic                            out_ovf
);

  // latched transaction
  logic                       cmd_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic                       end_r;
  logic [AGE_W-1:0]           age_r;

  // period accumulation
  logic [SQ_W-1:0]  sq_r;
  logic [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0] cnt_r;
  logic             ovf_r;

  // restoring divider
  logic [SUM_W-1:0] quo_r;
  logic [REM_W-1:0] rem_r;
  logic [REM_W-1:0] rem_sh;
  logic             q_bit;

  // digit-by-digit square root
  logic [MEAN_W-1:0] src_r;
  logic [SREM_W-1:0] srem_r;
  logic [ROOT_W-1:0] root_r;
  logic [SREM_W+1:0] srem_sh;
  logic [SREM_W+1:0] trial;
  logic              r_bit;

  // history ring
  logic [LEVEL_W-1:0] hist_mem [HIST_DEPTH];
  logic [HIST_DEPTH-1:0] hist_vld_r;
  logic [HIST_AW-1:0]    slot_r;
  logic [HIST_AW-1:0]    rd_idx;
  logic [LEVEL_W-1:0]    rd_data_r;
  logic                  rd_vld_r;

  logic                  out_valid_r;
  logic                  out_kind_r;
  logic [LEVEL_W-1:0]    out_level_r;
  logic                  out_ovf_r;

  logic [SAMPLE_W:0]     mag;

  assign mag     = sample_r[SAMPLE_W-1] ? (SAMPLE_W+1)'(-$signed({sample_r[SAMPLE_W-1], sample_r}))
                                        : {1'b0, sample_r};
  assign rem_sh  = {rem_r[REM_W-2:0], quo_r[SUM_W-1]};
  assign q_bit   = (rem_sh >= REM_W'(cnt_r));
  assign srem_sh = {srem_r, src_r[MEAN_W-1 -: 2]};
  assign trial   = {2'b00, root_r, 2'b01};
  assign r_bit   = (srem_sh >= trial);
  // newest entry sits one below the write slot; ring wrap by truncation
  assign rd_idx  = slot_r - HIST_AW'(1) - age_r[HIST_AW-1:0];

  assign sts.is_read  = cmd_r;
  assign sts.is_end   = end_r;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_level = out_level_r;
  assign out_ovf   = out_ovf_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r    <= in_cmd;
      sample_r <= in_sample;
      end_r    <= in_end;
      age_r    <= in_age;
    end
    if (cmd.square) sq_r <= SQ_W'(mag) * SQ_W'(mag);

    if (cmd.div_init) begin
      quo_r <= sum_r;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= q_bit ? (rem_sh - REM_W'(cnt_r)) : rem_sh;
      quo_r <= {quo_r[SUM_W-2:0], q_bit};
    end

    if (cmd.sqrt_init) begin
      // an empty period yields level zero
      src_r  <= (cnt_r == '0) ? '0 : quo_r[MEAN_W-1:0];
      srem_r <= '0;
      root_r <= '0;
    end else if (cmd.sqrt_step) begin
      srem_r <= r_bit ? SREM_W'(srem_sh - trial) : SREM_W'(srem_sh);
      root_r <= {root_r[ROOT_W-2:0], r_bit};
      src_r  <= {src_r[MEAN_W-3:0], 2'b00};
    end

    if (cmd.mem_rd) begin
      rd_data_r <= hist_mem[rd_idx];
      rd_vld_r  <= hist_vld_r[rd_idx];
    end
    if (cmd.emit_level) hist_mem[slot_r] <= root_r;

    if (cmd.emit_level) begin
      out_kind_r  <= KIND_LEVEL;
      out_level_r <= root_r;
      out_ovf_r   <= ovf_r;
    end else if (cmd.emit_read) begin
      out_kind_r  <= KIND_READ;
      out_level_r <= rd_vld_r ? rd_data_r : '0;
      out_ovf_r   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      slot_r      <= '0;
      hist_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.emit_level) begin
        sum_r              <= '0;
        cnt_r              <= '0;
        ovf_r              <= 1'b0;
        hist_vld_r[slot_r] <= 1'b1;
        slot_r             <= slot_r + 1'b1;
      end else if (cmd.accum) begin
        if (cnt_r < CNT_W'(MAX_SAMPLES)) begin
          sum_r <= sum_r + SUM_W'(sq_r);
          cnt_r <= cnt_r + 1'b1;
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.emit_level || cmd.emit_read) out_valid_r <= 1'b1;
      else if (out_ready)                  out_valid_r <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/audio_period_rms_meter.sv -----
`default_nettype none
// channel  | valid/ready            | payload
// in_      | in_tvalid/in_tready    | tdata sample,age; tuser command; tlast period_end
// out_     | out_tvalid/out_tready  | tdata level,overflowed; tuser kind
//
// One transaction at a time. A plain sample is loaded, squared and accumulated;
// a read is loaded and waits for a free output register. A period-closing sample
// then runs setup, the bit-serial divider, setup, the square root and output load.
// Synchronous active-low reset; the history ring reads as zero until written.
// A result waits in the output register; a new result stalls only while it is full.
module audio_period_rms_meter
  import apm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [15:0] sample, [22:16] age, [23] zero
  input  wire logic        in_tuser,   // command
  input  wire logic        in_tlast,   // period_end
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [15:0] level, [16] overflowed, [23:17] zero
  output logic             out_tuser   // kind
);

  dp_cmd_t            cmd;
  dp_sts_t            sts;
  logic [LEVEL_W-1:0] level;
  logic               ovf;

  apm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  apm_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_cmd    (in_tuser),
    .in_sample (in_tdata[SAMPLE_W-1:0]),
    .in_end    (in_tlast),
    .in_age    (in_tdata[SAMPLE_W +: AGE_W]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_tuser),
    .out_level (level),
    .out_ovf   (ovf)
  );

  assign out_tdata = {7'd0, ovf, level};

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a transaction is in progress");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_level || cmd.emit_read) |-> sts.out_free)
    else $error("result loaded over a pending output");

  a_emit_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.emit_level && cmd.emit_read))
    else $error("level and read emitted together");

  a_emit_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_level || cmd.emit_read) |=> out_tvalid)
    else $error("emitted result not presented");

endmodule
`default_nettype wire
